>>> rtl/stl_pkg.sv
// Package for the sorted tick list: field widths, operation and status codes,
// and default sizes. Used by the top level and the link memory.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    // Fixed widths of the transaction fields
    localparam int ID_BITS     = 6;
    localparam int KEY_IN_BITS = 32;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 2;
    localparam int FUNC_BITS   = 2;

    // Handle space reachable through the item_id field
    localparam int ID_SPACE = 2 ** ID_BITS;

    // Default sizes
    localparam int DEF_MAX_ITEMS = 64;
    localparam int DEF_KEY_BITS  = 32;

    // Operation codes
    localparam logic [FUNC_BITS-1:0] FUNC_SORTED = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_AT_END = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd3;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_PRESENT = 2'd2;
    localparam logic [STATUS_BITS-1:0] STAT_ABSENT  = 2'd3;

    // Read and write enables of one list memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } stl_mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sorted_tick_list.sv
// Sorted tick list: sequencer, sentinel links, member flags and output register.
// Clear and failed requests go from idle to head fetch and result; remove unlinks first, and
// inserts write both link pairs first, after a cursor read or a sorted walk where needed.
// Throughput: one transaction at a time; the walk reads one key and link per cycle,
// and a stalled output holds the sequencer in its result state.
// Reset: empty list, sentinel linked to itself, cursor on the sentinel; no sweep.
`timescale 1ns / 1ps
`default_nettype none

module sorted_tick_list
    import stl_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS,
    parameter int KEY_BITS  = DEF_KEY_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // func [1:0], item_id [7:2], key [39:8]
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // count [6:0], status [8:7], head_valid [9], head_item [15:10], head_key [47:16]
    output logic      [47:0] m_axis_tdata
);

    // Handles beyond the item_id field can never be stored
    localparam int NUM_IDS = (MAX_ITEMS < ID_SPACE) ? MAX_ITEMS : ID_SPACE;
    localparam int IW      = $clog2(NUM_IDS);
    localparam int LW      = $clog2(NUM_IDS + 1);

    localparam logic [LW-1:0]       SENT     = LW'(NUM_IDS);
    localparam logic [ID_BITS:0]    ID_LIMIT = (ID_BITS + 1)'(NUM_IDS);
    localparam logic [KEY_BITS-1:0] KEY_ALL  = {KEY_BITS{1'b1}};

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_CUR    = 3'd2;
    localparam logic [2:0] ST_RM     = 3'd3;
    localparam logic [2:0] ST_LINK1  = 3'd4;
    localparam logic [2:0] ST_LINK2  = 3'd5;
    localparam logic [2:0] ST_HEAD   = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    // Input fields
    logic [FUNC_BITS-1:0] in_func;
    logic [ID_BITS-1:0]   in_id;
    logic [KEY_BITS-1:0]  in_key;
    logic                 in_ok;
    logic [LW-1:0]        in_lid;

    assign in_func = s_axis_tdata[1:0];
    assign in_id   = s_axis_tdata[7:2];
    assign in_key  = KEY_BITS'(s_axis_tdata[39:8]);
    assign in_ok   = ({1'b0, in_id} < ID_LIMIT);
    assign in_lid  = LW'(in_id);

    // Control and working registers
    logic [2:0]             state_reg, state_next;
    logic [FUNC_BITS-1:0]   func_reg, func_next;
    logic [LW-1:0]          id_reg, id_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [LW-1:0]          at_reg, at_next;
    logic [LW-1:0]          nx_reg, nx_next;
    logic [LW-1:0]          cand_reg, cand_next;
    logic [LW-1:0]          cursor_reg, cursor_next;
    logic [LW-1:0]          count_reg, count_next;
    logic [LW-1:0]          head_reg, head_next;
    logic [LW-1:0]          tail_reg, tail_next;
    logic [NUM_IDS-1:0]     member_reg, member_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [47:0]            out_data_reg, out_data_next;

    // Memory ports
    stl_mem_ctl_t        nl_ctl, pl_ctl, kv_ctl;
    logic [IW-1:0]       nl_wa, nl_ra, pl_wa, pl_ra, kv_wa, kv_ra;
    logic [LW-1:0]       nl_wd, nl_rd, pl_wd, pl_rd;
    logic [KEY_BITS-1:0] kv_wd, kv_rd;

    stl_ram #(.DEPTH(NUM_IDS), .WIDTH(LW)) u_next_link
    (
        .clk     (clk),
        .ctl     (nl_ctl),
        .wr_addr (nl_wa),
        .wr_data (nl_wd),
        .rd_addr (nl_ra),
        .rd_data (nl_rd)
    );

    stl_ram #(.DEPTH(NUM_IDS), .WIDTH(LW)) u_prev_link
    (
        .clk     (clk),
        .ctl     (pl_ctl),
        .wr_addr (pl_wa),
        .wr_data (pl_wd),
        .rd_addr (pl_ra),
        .rd_data (pl_rd)
    );

    stl_ram #(.DEPTH(NUM_IDS), .WIDTH(KEY_BITS)) u_item_value
    (
        .clk     (clk),
        .ctl     (kv_ctl),
        .wr_addr (kv_wa),
        .wr_data (kv_wd),
        .rd_addr (kv_ra),
        .rd_data (kv_rd)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Sequencer and walk key compare
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        at_next        = at_reg;
        nx_next        = nx_reg;
        cand_next      = cand_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        member_next    = member_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        nl_ctl = '0;
        pl_ctl = '0;
        kv_ctl = '0;
        nl_wa  = '0;
        nl_ra  = '0;
        nl_wd  = '0;
        pl_wa  = '0;
        pl_ra  = '0;
        pl_wd  = '0;
        kv_wa  = '0;
        kv_ra  = '0;
        kv_wd  = '0;

        // Drain the output register
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next   = in_func;
                    id_next     = in_lid;
                    key_next    = in_key;
                    status_next = STAT_OK;
                    state_next  = ST_HEAD;
                    if (in_func == FUNC_CLEAR)
                    begin
                        member_next = '0;
                        head_next   = SENT;
                        tail_next   = SENT;
                        cursor_next = SENT;
                        count_next  = '0;
                    end
                    else if (!in_ok)
                    begin
                        status_next = STAT_ABSENT;
                    end
                    else if (in_func == FUNC_REMOVE)
                    begin
                        if (!member_reg[in_id[IW-1:0]])
                        begin
                            status_next = STAT_ABSENT;
                        end
                        else
                        begin
                            // Fetch both neighbors of the item
                            nl_ctl.rd_en = 1'b1;
                            nl_ra        = in_id[IW-1:0];
                            pl_ctl.rd_en = 1'b1;
                            pl_ra        = in_id[IW-1:0];
                            state_next   = ST_RM;
                        end
                    end
                    else if (member_reg[in_id[IW-1:0]])
                    begin
                        status_next = STAT_PRESENT;
                    end
                    else if (count_reg >= SENT)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        kv_ctl.wr_en = 1'b1;
                        kv_wa        = in_id[IW-1:0];
                        kv_wd        = in_key;
                        if (in_func == FUNC_AT_END)
                        begin
                            if (cursor_reg == SENT)
                            begin
                                at_next    = tail_reg;
                                nx_next    = SENT;
                                state_next = ST_LINK1;
                            end
                            else
                            begin
                                pl_ctl.rd_en = 1'b1;
                                pl_ra        = cursor_reg[IW-1:0];
                                state_next   = ST_CUR;
                            end
                        end
                        else if (in_key == KEY_ALL || head_reg == SENT)
                        begin
                            // Wait forever goes to the tail; an empty list needs no walk
                            at_next    = tail_reg;
                            nx_next    = SENT;
                            state_next = ST_LINK1;
                        end
                        else
                        begin
                            at_next      = SENT;
                            cand_next    = head_reg;
                            kv_ctl.rd_en = 1'b1;
                            kv_ra        = head_reg[IW-1:0];
                            nl_ctl.rd_en = 1'b1;
                            nl_ra        = head_reg[IW-1:0];
                            state_next   = ST_WALK;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                // Advance past entries whose key is not above the new key
                if (kv_rd <= key_reg)
                begin
                    at_next = cand_reg;
                    if (nl_rd == SENT)
                    begin
                        nx_next    = SENT;
                        state_next = ST_LINK1;
                    end
                    else
                    begin
                        cand_next    = nl_rd;
                        kv_ctl.rd_en = 1'b1;
                        kv_ra        = nl_rd[IW-1:0];
                        nl_ctl.rd_en = 1'b1;
                        nl_ra        = nl_rd[IW-1:0];
                    end
                end
                else
                begin
                    nx_next    = cand_reg;
                    state_next = ST_LINK1;
                end
            end

            ST_CUR:
            begin
                at_next    = pl_rd;
                nx_next    = cursor_reg;
                state_next = ST_LINK1;
            end

            ST_LINK1:
            begin
                // Point the new item at its neighbors
                nl_ctl.wr_en = 1'b1;
                nl_wa        = id_reg[IW-1:0];
                nl_wd        = nx_reg;
                pl_ctl.wr_en = 1'b1;
                pl_wa        = id_reg[IW-1:0];
                pl_wd        = at_reg;
                state_next   = ST_LINK2;
            end

            ST_LINK2:
            begin
                // Point the neighbors at the new item
                if (at_reg == SENT)
                begin
                    head_next = id_reg;
                end
                else
                begin
                    nl_ctl.wr_en = 1'b1;
                    nl_wa        = at_reg[IW-1:0];
                    nl_wd        = id_reg;
                end
                if (nx_reg == SENT)
                begin
                    tail_next = id_reg;
                end
                else
                begin
                    pl_ctl.wr_en = 1'b1;
                    pl_wa        = nx_reg[IW-1:0];
                    pl_wd        = id_reg;
                end
                member_next[id_reg[IW-1:0]] = 1'b1;
                count_next = count_reg + LW'(1);
                state_next = ST_HEAD;
            end

            ST_RM:
            begin
                // Unlink the item and pull the cursor back if it sat there
                if (nl_rd == SENT)
                begin
                    tail_next = pl_rd;
                end
                else
                begin
                    pl_ctl.wr_en = 1'b1;
                    pl_wa        = nl_rd[IW-1:0];
                    pl_wd        = pl_rd;
                end
                if (pl_rd == SENT)
                begin
                    head_next = nl_rd;
                end
                else
                begin
                    nl_ctl.wr_en = 1'b1;
                    nl_wa        = pl_rd[IW-1:0];
                    nl_wd        = nl_rd;
                end
                if (cursor_reg == id_reg)
                begin
                    cursor_next = pl_rd;
                end
                member_next[id_reg[IW-1:0]] = 1'b0;
                count_next = count_reg - LW'(1);
                state_next = ST_HEAD;
            end

            ST_HEAD:
            begin
                // Fetch the key of the first entry
                if (head_reg != SENT)
                begin
                    kv_ctl.rd_en = 1'b1;
                    kv_ra        = head_reg[IW-1:0];
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next[6:0]   = COUNT_BITS'(count_reg);
                    out_data_next[8:7]   = status_reg;
                    if (count_reg != '0)
                    begin
                        out_data_next[9]     = 1'b1;
                        out_data_next[15:10] = ID_BITS'(head_reg);
                        out_data_next[47:16] = KEY_IN_BITS'(kv_rd);
                    end
                    else
                    begin
                        out_data_next[9]     = 1'b0;
                        out_data_next[15:10] = '0;
                        out_data_next[47:16] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= SENT;
            count_reg     <= '0;
            head_reg      <= SENT;
            tail_reg      <= SENT;
            member_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            member_reg    <= member_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        id_reg       <= id_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        at_reg       <= at_next;
        nx_reg       <= nx_next;
        cand_reg     <= cand_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/stl_ram.sv
// One-write, one-read memory with a registered read port.
// Holds link or key entries of the sorted tick list; depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_ram
    import stl_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ITEMS,
    parameter int WIDTH = DEF_KEY_BITS
)
(
    input  wire logic                     clk,
    input  wire stl_mem_ctl_t             ctl,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; hold data when not reading
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/stl_checker.sv
// Checker for the sorted tick list: watches both stream channels, predicts each
// response from a private copy of the list, and counts mismatches.
// Depends on stl_pkg for operation and status codes and default sizes.
`timescale 1ns / 1ps

module stl_checker
    import stl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // func [1:0], item_id [7:2], key [39:8]
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // count [6:0], status [8:7], head_valid [9], head_item [15:10], head_key [47:16]
    input  logic [47:0] m_axis_tdata,
    output int          fail_count,
    output int          pending
);

    // Response layout, lowest field in the lowest bits
    typedef struct packed {
        logic [31:0] head_key;
        logic [5:0]  head_item;
        logic        head_valid;
        logic [1:0]  status;
        logic [6:0]  count;
    } tick_resp_t;

    localparam int          SENTINEL = DEF_MAX_ITEMS;
    localparam logic [31:0] WAIT_MAX = '1;

    // Shadow copy of the list
    logic [6:0]  nxt [0:SENTINEL];
    logic [6:0]  prv [0:SENTINEL];
    logic [31:0] tick [0:SENTINEL-1];
    bit          listed [0:SENTINEL-1];
    logic [6:0]  cur;
    int          n_items;

    tick_resp_t  resp_q [$];
    tick_resp_t  want;
    tick_resp_t  got;
    int          errs = 0;

    function automatic void reset_list();
        for (int i = 0; i <= SENTINEL; i++)
        begin
            nxt[i] = '0;
            prv[i] = '0;
        end
        for (int i = 0; i < SENTINEL; i++)
        begin
            tick[i]   = '0;
            listed[i] = 1'b0;
        end
        nxt[SENTINEL] = 7'(SENTINEL);
        prv[SENTINEL] = 7'(SENTINEL);
        cur     = 7'(SENTINEL);
        n_items = 0;
    endfunction

    // The sentinel reads as the maximum key
    function automatic logic [31:0] tick_at(int e);
        if (e >= SENTINEL)
            return WAIT_MAX;
        return tick[e];
    endfunction

    function automatic void splice_after(int at, int it);
        int nx;
        nx          = nxt[at];
        nxt[it]     = 7'(nx);
        prv[nx]     = 7'(it);
        prv[it]     = 7'(at);
        nxt[at]     = 7'(it);
        listed[it]  = 1'b1;
        n_items++;
    endfunction

    // Apply one request to the shadow list and build its response
    function automatic tick_resp_t apply_list_op(logic [1:0] op, logic [5:0] id,
                                                 logic [31:0] k);
        tick_resp_t r;
        logic [1:0] st;
        int         at;
        int         steps;
        int         p;
        int         n;
        st = STAT_OK;
        if (op == FUNC_CLEAR)
            reset_list();
        else if (int'(id) >= SENTINEL)
            st = STAT_ABSENT;
        else if (op == FUNC_REMOVE)
        begin
            if (!listed[id])
                st = STAT_ABSENT;
            else
            begin
                p = prv[id];
                n = nxt[id];
                prv[n] = 7'(p);
                nxt[p] = 7'(n);
                if (cur == 7'(id))
                    cur = 7'(p);
                listed[id] = 1'b0;
                n_items--;
            end
        end
        else if (listed[id])
            st = STAT_PRESENT;
        else if (n_items >= SENTINEL)
            st = STAT_FULL;
        else
        begin
            tick[id] = k;
            if (op == FUNC_AT_END)
                splice_after(prv[cur], id);
            else
            begin
                // Maximum key goes straight to the tail; otherwise walk past
                // every entry with a key not above the new one
                if (k == WAIT_MAX)
                    at = prv[SENTINEL];
                else
                begin
                    at    = SENTINEL;
                    steps = 0;
                    while (nxt[at] != 7'(SENTINEL) && tick_at(nxt[at]) <= k
                           && steps <= SENTINEL)
                    begin
                        at = nxt[at];
                        steps++;
                    end
                end
                splice_after(at, id);
            end
        end
        r.count  = 7'(n_items);
        r.status = st;
        if (n_items > 0)
        begin
            r.head_valid = 1'b1;
            r.head_item  = nxt[SENTINEL][5:0];
            r.head_key   = tick_at(nxt[SENTINEL]);
        end
        else
        begin
            r.head_valid = 1'b0;
            r.head_item  = '0;
            r.head_key   = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errs++;
        end
    endtask

    initial
    begin
        reset_list();
    end

    // Predict on each request transaction, compare on each response transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_list();
            resp_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                resp_q.push_back(apply_list_op(s_axis_tdata[1:0], s_axis_tdata[7:2],
                                               s_axis_tdata[39:8]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (resp_q.size() == 0)
                begin
                    $display("%0t: response with no request pending: expected none, actual %h",
                             $time, got);
                    errs++;
                end
                else
                begin
                    want = resp_q.pop_front();
                    check_field("count", 32'(want.count), 32'(got.count));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
                    check_field("head_item", 32'(want.head_item), 32'(got.head_item));
                    check_field("head_key", want.head_key, got.head_key);
                end
            end
        end
        pending    <= resp_q.size();
        fail_count <= errs;
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the sorted tick list testbench: clock, reset, request stimulus and
// response back-pressure, and the final verdict.
// Depends on stl_pkg, the sorted_tick_list RTL and stl_checker.
`timescale 1ns / 1ps

module tb_top;
    import stl_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int LIST_SIZE    = DEF_MAX_ITEMS;

    typedef enum int { PH_FILL, PH_GROW, PH_SHRINK, PH_MIXED } phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    int          fail_count;
    int          pending;

    // Stimulus-side view of which handles are linked
    bit [LIST_SIZE-1:0] in_list;
    int                 live;
    bit                 quiet;
    int                 rand_sent;

    sorted_tick_list DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stl_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [5:0] pick_free();
        logic [5:0] c;
        c = 6'($urandom_range(0, LIST_SIZE - 1));
        if (live < LIST_SIZE)
            while (in_list[c])
                c = 6'($urandom_range(0, LIST_SIZE - 1));
        return c;
    endfunction

    function automatic logic [5:0] pick_member();
        logic [5:0] c;
        c = 6'($urandom_range(0, LIST_SIZE - 1));
        if (live > 0)
            while (!in_list[c])
                c = 6'($urandom_range(0, LIST_SIZE - 1));
        return c;
    endfunction

    // Favor ties, the extremes and the wait-forever key
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'hFFFF_FFFE;
            3, 4:    return 32'($urandom_range(0, 15));
            5:       return 32'($urandom_range(1000, 1031));
            default: return $urandom;
        endcase
    endfunction

    task automatic choose_op(input phase_t mode, output logic [1:0] op,
                             output logic [5:0] id, output logic [31:0] k);
        int r;
        r  = $urandom_range(0, 99);
        k  = pick_key();
        op = FUNC_SORTED;
        id = pick_free();
        case (mode)
            PH_FILL:
            begin
                if (r >= 70)
                    op = FUNC_AT_END;
                if (live >= LIST_SIZE && r < 30)
                    id = pick_member();
            end
            PH_GROW:
            begin
                if (r >= 55 && r < 75)
                    op = FUNC_AT_END;
                else if (r >= 75 && r < 80)
                    id = pick_member();
                else if (r >= 80 && r < 97)
                begin
                    op = FUNC_REMOVE;
                    id = pick_member();
                end
                else if (r >= 97)
                begin
                    op = FUNC_REMOVE;
                    id = 6'($urandom);
                end
            end
            PH_SHRINK:
            begin
                op = FUNC_REMOVE;
                if (r < 60)
                    id = pick_member();
                else if (r < 75)
                    id = 6'($urandom);
                else if (r < 90)
                    op = FUNC_SORTED;
                else
                    op = FUNC_AT_END;
            end
            default:
            begin
                if (r >= 35 && r < 50)
                    op = FUNC_AT_END;
                else if (r >= 50 && r < 80)
                begin
                    op = FUNC_REMOVE;
                    id = pick_member();
                end
                else if (r >= 80 && r < 90)
                begin
                    op = FUNC_REMOVE;
                    id = 6'($urandom);
                end
                else if (r >= 90 && r < 97)
                begin
                    op = 2'($urandom_range(0, 1));
                    id = 6'($urandom);
                end
                else if (r >= 97)
                    op = FUNC_CLEAR;
            end
        endcase
    endtask

    // Present one request, with an optional idle burst first; hold it until accepted
    task automatic drive_op(input logic [1:0] op, input logic [5:0] id, input logic [31:0] k);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {k, id, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (op)
            FUNC_CLEAR:
            begin
                in_list = '0;
                live    = 0;
            end
            FUNC_REMOVE:
            begin
                if (in_list[id])
                begin
                    in_list[id] = 1'b0;
                    live--;
                end
            end
            default:
            begin
                if (!in_list[id] && live < LIST_SIZE)
                begin
                    in_list[id] = 1'b1;
                    live++;
                end
            end
        endcase
    endtask

    // Stop sending and hold until every response has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Response back-pressure in random bursts
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(0, 9);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 15);
            end
        end
    end

    // Request stimulus and verdict
    initial
    begin
        phase_t      mode;
        int          plen;
        bit          filled;
        logic [1:0]  op;
        logic [5:0]  id;
        logic [31:0] k;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        rst_n         <= 1'b0;
        in_list   = '0;
        live      = 0;
        quiet     = 1'b0;
        rand_sent = 0;
        filled    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, ties, extremes, duplicates, absent removes, clear
        drive_op(FUNC_CLEAR,  6'd5,  32'h0);
        drive_op(FUNC_REMOVE, 6'd5,  32'h0);
        drive_op(FUNC_SORTED, 6'd0,  32'h0);
        drive_op(FUNC_SORTED, 6'd63, 32'hFFFF_FFFF);
        drive_op(FUNC_SORTED, 6'd10, 32'd100);
        drive_op(FUNC_SORTED, 6'd11, 32'd100);
        drive_op(FUNC_SORTED, 6'd12, 32'd99);
        drive_op(FUNC_AT_END, 6'd20, 32'd5);
        drive_op(FUNC_SORTED, 6'd21, 32'hFFFF_FFFE);
        drive_op(FUNC_SORTED, 6'd0,  32'd7);
        drive_op(FUNC_AT_END, 6'd63, 32'd1);
        drive_op(FUNC_REMOVE, 6'd0,  32'hFFFF_FFFF);
        drive_op(FUNC_REMOVE, 6'd63, 32'h0);
        drive_op(FUNC_REMOVE, 6'd0,  32'h0);
        drive_op(FUNC_REMOVE, 6'd20, 32'h0);
        drive_op(FUNC_SORTED, 6'd42, 32'hAAAA_AAAA);
        drive_op(FUNC_SORTED, 6'd1,  32'h5555_5555);
        drive_op(FUNC_AT_END, 6'd2,  32'hFFFF_FFFF);
        drive_op(FUNC_CLEAR,  6'd63, 32'hFFFF_FFFF);
        drive_op(FUNC_SORTED, 6'd33, 32'h8000_0000);
        drive_op(FUNC_REMOVE, 6'd33, 32'h0);
        wait_drained();

        // Random phases; the first one fills the list and then retries handles already listed
        while (rand_sent < RANDOM_ITEMS)
        begin
            if (!filled)
                mode = PH_FILL;
            else
                mode = phase_t'($urandom_range(0, 3));
            if (mode == PH_FILL)
                plen = LIST_SIZE - live + $urandom_range(3, 8);
            else
                plen = $urandom_range(10, 80);
            filled = 1'b1;
            for (int j = 0; j < plen && rand_sent < RANDOM_ITEMS; j++)
            begin
                choose_op(mode, op, id, k);
                drive_op(op, id, k);
                rand_sent++;
                quiet = (rand_sent >= RANDOM_ITEMS - 80);
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
